[sv/rshd_pkg.sv]
// Shared widths, register codes and payload types for the ray/sphere hit distance block.
// Depends on nothing; rshd_front, rshd_back and the top level import it.
package rshd_pkg;

  localparam int unsigned CRD_W     = 32;  // coordinate width, signed fixed point
  localparam int unsigned RAD_W     = 31;  // radius and distance width
  localparam int unsigned CFG_IDX_W = 2;
  // Widths below cover the smallest supported fraction width (8 bits).
  localparam int unsigned RT_W      = 58;  // projected center distance rt
  localparam int unsigned DISC_W    = 119; // signed discriminant
  localparam int unsigned SQ_W      = 59;  // square root result bits
  localparam int unsigned RADX_W    = 2 * SQ_W;
  localparam int unsigned REM_W     = SQ_W + 2;
  localparam int unsigned T_W       = 61;  // signed root candidates

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CENTER_X = 2'd0,
    CFG_CENTER_Y = 2'd1,
    CFG_CENTER_Z = 2'd2,
    CFG_RADIUS   = 2'd3
  } cfg_reg_e;

  // Item handed from the front end to the back end.
  typedef struct packed {
    logic [2:0][CRD_W-1:0] org;
    logic [2:0][CRD_W-1:0] dir;
    logic [RT_W-1:0]       rt;
    logic [DISC_W-1:0]     disc;
  } rshd_mid_t;

  // Finished result.
  typedef struct packed {
    logic                  hit;
    logic [RAD_W-1:0]      hit_dist;
    logic [2:0][CRD_W-1:0] pt;
  } rshd_res_t;

endpackage

[sv/rshd_fifo.sv]
// Small first-in first-out queue with push/full and pop/empty sides.
// Depends on nothing; DEPTH must be a power of two.
module rshd_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 4
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [WIDTH-1:0] data_o,
  output logic             empty_o
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             wr, rd;

  assign full_o  = (cnt_q == CNT_W'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign wr      = push_i & ~full_o;
  assign rd      = pop_i & ~empty_o;
  assign data_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr ? wr_ptr_q + PTR_W'(1) : wr_ptr_q;
    rd_ptr_d = rd ? rd_ptr_q + PTR_W'(1) : rd_ptr_q;
    cnt_d    = cnt_q + CNT_W'(wr) - CNT_W'(rd);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

[sv/rshd_front.sv]
// Front end: sphere registers, center offset, dot products and the discriminant.
// Depends on rshd_pkg; five pipeline stages that stall together.
module rshd_front import rshd_pkg::*; #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CRD_W-1:0]      cfg_wdata_i,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic [2:0][CRD_W-1:0] org_i,
  input  logic [2:0][CRD_W-1:0] dir_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output rshd_mid_t             out_data_o
);

  localparam int unsigned DIFF_W = CRD_W + 1;
  localparam int unsigned PM_W   = DIFF_W + CRD_W;
  localparam int unsigned ACC_W  = PM_W + 1;
  localparam int unsigned DQ_W   = 2 * DIFF_W;
  localparam int unsigned RR_W   = 2 * RAD_W;
  localparam int unsigned BASE_W = DQ_W + 1;
  localparam int unsigned HALF_W = RT_W / 2;
  localparam int unsigned PP_W   = 2 * HALF_W;

  logic [2:0][CRD_W-1:0] center_q;
  logic [RAD_W-1:0]      radius_q;

  logic [4:0] v_q;
  logic       en;

  logic [2:0][CRD_W-1:0] org1_q, dir1_q, org2_q, dir2_q, org3_q, dir3_q;
  logic [2:0][CRD_W-1:0] org4_q, dir4_q, org5_q, dir5_q;
  logic signed [DIFF_W-1:0] d1_q [3];
  logic signed [PM_W-1:0]   pm2_q [3];
  logic signed [DQ_W-1:0]   dq2_q [3];
  logic [RR_W-1:0]          rr2_q, rr3_q;
  logic signed [ACC_W-1:0]  acc3_q, acc_sh;
  // The squared length is never negative but can use the top bit.
  logic [DQ_W-1:0]          dsq3_q;
  logic signed [RT_W-1:0]   rt, rt4_q, rt5_q;
  logic [RT_W-1:0]          rt_mag;
  logic [PP_W-1:0]          pll4_q, plh4_q, phh4_q;
  logic signed [BASE_W-1:0] base4_q;
  logic signed [DISC_W-1:0] disc5_q;

  assign en          = ~v_q[4] | out_ready_i;
  assign in_ready_o  = en;
  assign out_valid_o = v_q[4];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      center_q <= '0;
      radius_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_idx_i))
        CFG_CENTER_X: center_q[0] <= cfg_wdata_i;
        CFG_CENTER_Y: center_q[1] <= cfg_wdata_i;
        CFG_CENTER_Z: center_q[2] <= cfg_wdata_i;
        CFG_RADIUS:   radius_q    <= cfg_wdata_i[RAD_W-1:0];
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en) begin
      v_q <= {v_q[3:0], in_valid_i};
    end
  end

  assign acc_sh = acc3_q >>> FRAC_BITS;
  assign rt     = acc_sh[RT_W-1:0];
  assign rt_mag = rt[RT_W-1] ? RT_W'(-rt) : RT_W'(rt);

  always_ff @(posedge clk_i) begin
    if (en) begin
      // Stage 1: offset from the ray origin to the center.
      org1_q <= org_i;
      dir1_q <= dir_i;
      for (int i = 0; i < 3; i++) begin
        d1_q[i] <= $signed({center_q[i][CRD_W-1], center_q[i]})
                 - $signed({org_i[i][CRD_W-1], org_i[i]});
      end
      // Stage 2: products.
      org2_q <= org1_q;
      dir2_q <= dir1_q;
      for (int i = 0; i < 3; i++) begin
        pm2_q[i] <= d1_q[i] * $signed(dir1_q[i]);
        dq2_q[i] <= d1_q[i] * d1_q[i];
      end
      rr2_q <= radius_q * radius_q;
      // Stage 3: sums.
      org3_q <= org2_q;
      dir3_q <= dir2_q;
      acc3_q <= ACC_W'(pm2_q[0]) + ACC_W'(pm2_q[1]) + ACC_W'(pm2_q[2]);
      dsq3_q <= dq2_q[0] + dq2_q[1] + dq2_q[2];
      rr3_q  <= rr2_q;
      // Stage 4: rt squared as partial products of its magnitude.
      org4_q  <= org3_q;
      dir4_q  <= dir3_q;
      rt4_q   <= rt;
      pll4_q  <= rt_mag[HALF_W-1:0] * rt_mag[HALF_W-1:0];
      plh4_q  <= rt_mag[HALF_W-1:0] * rt_mag[RT_W-1:HALF_W];
      phh4_q  <= rt_mag[RT_W-1:HALF_W] * rt_mag[RT_W-1:HALF_W];
      base4_q <= $signed({{(BASE_W-RR_W){1'b0}}, rr3_q}) - BASE_W'(dsq3_q);
      // Stage 5: discriminant.
      org5_q  <= org4_q;
      dir5_q  <= dir4_q;
      rt5_q   <= rt4_q;
      disc5_q <= $signed({{(DISC_W-PP_W){1'b0}}, pll4_q})
               + $signed({{(DISC_W-PP_W-HALF_W-1){1'b0}}, plh4_q, {(HALF_W+1){1'b0}}})
               + $signed({{(DISC_W-2*PP_W){1'b0}}, phh4_q, {PP_W{1'b0}}})
               + $signed({{(DISC_W-BASE_W){base4_q[BASE_W-1]}}, base4_q});
    end
  end

  assign out_data_o.org  = org5_q;
  assign out_data_o.dir  = dir5_q;
  assign out_data_o.rt   = rt5_q;
  assign out_data_o.disc = disc5_q;

endmodule

[sv/rshd_back.sv]
// Back end: bit-per-stage square root, root selection, hit point and saturation.
// Depends on rshd_pkg; all stages stall together when the last stage holds a result that is not taken.
module rshd_back import rshd_pkg::*; #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  rshd_mid_t in_data_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output rshd_res_t out_data_o
);

  localparam int unsigned NSTG    = SQ_W + 4;
  localparam int unsigned TL_W    = CRD_W;
  localparam int unsigned TH_W    = T_W - 1 - TL_W;
  localparam int unsigned PLO_W   = CRD_W + TL_W + 1;
  localparam int unsigned PHI_W   = CRD_W + TH_W + 1;
  localparam int unsigned PROD_W  = PHI_W + TL_W;
  localparam int unsigned PSUM_W  = PROD_W + 1;

  typedef struct packed {
    logic                  neg;
    logic [RT_W-1:0]       rt;
    logic [2:0][CRD_W-1:0] org;
    logic [2:0][CRD_W-1:0] dir;
  } side_t;

  logic [NSTG-1:0] v_q;
  logic            en;

  logic [RADX_W-1:0] rad_q  [SQ_W];
  logic [REM_W-1:0]  rem_q  [SQ_W];
  logic [SQ_W-1:0]   root_q [SQ_W];
  side_t             side_q [SQ_W];

  side_t                 side0;
  logic [RADX_W-1:0]     rad0;
  side_t                 last;
  logic signed [T_W-1:0] t1, t2, rt_x, s_x;
  logic                  miss;

  logic                     sel_hit_q;
  logic signed [T_W-1:0]    sel_t_q;
  logic [2:0][CRD_W-1:0]    sel_org_q, sel_dir_q;
  logic                     mul_hit_q, sum_hit_q;
  logic [RAD_W-1:0]         mul_dist_q, sum_dist_q;
  logic [2:0][CRD_W-1:0]    mul_org_q;
  logic signed [PLO_W-1:0]  plo_q [3];
  logic signed [PHI_W-1:0]  phi_q [3];
  logic signed [PSUM_W-1:0] psum_q [3];
  logic signed [PROD_W-1:0] prod [3];
  rshd_res_t                res_q;

  function automatic logic [CRD_W-1:0] sat32(input logic signed [PSUM_W-1:0] v);
    logic signed [PSUM_W-1:0] hi_lim;
    logic signed [PSUM_W-1:0] lo_lim;
    hi_lim = $signed({{(PSUM_W-CRD_W+1){1'b0}}, {(CRD_W-1){1'b1}}});
    lo_lim = $signed({{(PSUM_W-CRD_W+1){1'b1}}, {(CRD_W-1){1'b0}}});
    if (v > hi_lim) begin
      return {1'b0, {(CRD_W-1){1'b1}}};
    end else if (v < lo_lim) begin
      return {1'b1, {(CRD_W-1){1'b0}}};
    end else begin
      return v[CRD_W-1:0];
    end
  endfunction

  assign en          = ~v_q[NSTG-1] | out_ready_i;
  assign in_ready_o  = en;
  assign out_valid_o = v_q[NSTG-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en) begin
      v_q <= {v_q[NSTG-2:0], in_valid_i};
    end
  end

  // A negative discriminant is a miss; its root is not needed.
  assign side0.neg = in_data_i.disc[DISC_W-1];
  assign side0.rt  = in_data_i.rt;
  assign side0.org = in_data_i.org;
  assign side0.dir = in_data_i.dir;
  assign rad0      = side0.neg ? '0 : in_data_i.disc[RADX_W-1:0];

  for (genvar k = 0; k < SQ_W; k++) begin : g_sqrt
    logic [RADX_W-1:0] rad_in;
    logic [REM_W-1:0]  rem_in, cur, trial;
    logic [SQ_W-1:0]   root_in;
    side_t             side_in;
    logic              ge;

    if (k == 0) begin : g_first
      assign rad_in  = rad0;
      assign rem_in  = '0;
      assign root_in = '0;
      assign side_in = side0;
    end else begin : g_next
      assign rad_in  = rad_q[k-1];
      assign rem_in  = rem_q[k-1];
      assign root_in = root_q[k-1];
      assign side_in = side_q[k-1];
    end

    assign cur   = {rem_in[REM_W-3:0], rad_in[RADX_W-1 -: 2]};
    assign trial = {root_in, 2'b01};
    assign ge    = (cur >= trial);

    always_ff @(posedge clk_i) begin
      if (en) begin
        rad_q[k]  <= {rad_in[RADX_W-3:0], 2'b00};
        rem_q[k]  <= ge ? cur - trial : cur;
        root_q[k] <= {root_in[SQ_W-2:0], ge};
        side_q[k] <= side_in;
      end
    end
  end

  assign last = side_q[SQ_W-1];
  assign rt_x = $signed({{(T_W-RT_W){last.rt[RT_W-1]}}, last.rt});
  assign s_x  = $signed({{(T_W-SQ_W){1'b0}}, root_q[SQ_W-1]});
  assign t1   = rt_x + s_x;
  assign t2   = rt_x - s_x;
  assign miss = last.neg | t1[T_W-1];

  for (genvar i = 0; i < 3; i++) begin : g_prod
    assign prod[i] = $signed({phi_q[i], {TL_W{1'b0}}})
                   + $signed({{(PROD_W-PLO_W){plo_q[i][PLO_W-1]}}, plo_q[i]});
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      // Nearer root when it lies strictly ahead, else the farther one.
      sel_hit_q <= ~miss;
      if (miss) begin
        sel_t_q <= '0;
      end else if (t2 > 0) begin
        sel_t_q <= t2;
      end else begin
        sel_t_q <= t1;
      end
      sel_org_q <= last.org;
      sel_dir_q <= last.dir;

      mul_hit_q  <= sel_hit_q;
      mul_org_q  <= sel_org_q;
      mul_dist_q <= (|sel_t_q[T_W-2:RAD_W]) ? '1 : sel_t_q[RAD_W-1:0];
      for (int i = 0; i < 3; i++) begin
        plo_q[i] <= $signed(sel_dir_q[i]) * $signed({1'b0, sel_t_q[TL_W-1:0]});
        phi_q[i] <= $signed(sel_dir_q[i]) * $signed({1'b0, sel_t_q[T_W-2:TL_W]});
      end

      sum_hit_q  <= mul_hit_q;
      sum_dist_q <= mul_dist_q;
      for (int i = 0; i < 3; i++) begin
        psum_q[i] <= $signed({{(PSUM_W-CRD_W){mul_org_q[i][CRD_W-1]}}, mul_org_q[i]})
                   + PSUM_W'(prod[i] >>> FRAC_BITS);
      end

      res_q.hit      <= sum_hit_q;
      res_q.hit_dist <= sum_hit_q ? sum_dist_q : '0;
      for (int i = 0; i < 3; i++) begin
        res_q.pt[i] <= sum_hit_q ? sat32(psum_q[i]) : '0;
      end
    end
  end

  assign out_data_o = res_q;

endmodule

[sv/ray_sphere_hit_distance.sv]
// Top level of the ray/sphere hit distance block.
// Depends on rshd_pkg, rshd_front, rshd_fifo and rshd_back.
//
// Usage:
//   Write the sphere through cfg_we_i/cfg_idx_i/cfg_wdata_i: index 0..2 is the
//   center x/y/z, index 3 the radius. Writes take effect at once; the user must
//   make them only while no ray is in flight, as the block does not enforce it.
//   Rays enter on the push/full side: a transfer happens at a clock edge with
//   push high and full low. Results leave on the empty/pop side: the oldest
//   result sits on the output ports while empty is low and is removed by pop.
// Throughput: one ray per cycle, sustained, as long as results are popped.
// The square root in the back end has 59 stages, one per result bit.
// A five-stage front end feeds a four-entry queue; the back end drains it.
//   If the receiver stops popping, the back end holds, the queue fills, and
//   then full rises; nothing is dropped.
// Reset clears the sphere registers to zero and empties every queue.
module ray_sphere_hit_distance import rshd_pkg::*; #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_we_i,
  input  logic [CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [CRD_W-1:0]         cfg_wdata_i,
  input  logic                     push,
  output logic                     full,
  input  logic signed [CRD_W-1:0]  origin_x_i,
  input  logic signed [CRD_W-1:0]  origin_y_i,
  input  logic signed [CRD_W-1:0]  origin_z_i,
  input  logic signed [CRD_W-1:0]  dir_x_i,
  input  logic signed [CRD_W-1:0]  dir_y_i,
  input  logic signed [CRD_W-1:0]  dir_z_i,
  output logic                     empty,
  input  logic                     pop,
  output logic                     hit_o,
  output logic [RAD_W-1:0]         hit_distance_o,
  output logic signed [CRD_W-1:0]  hit_x_o,
  output logic signed [CRD_W-1:0]  hit_y_o,
  output logic signed [CRD_W-1:0]  hit_z_o
);

  localparam int unsigned MID_W = $bits(rshd_mid_t);
  localparam int unsigned RES_W = $bits(rshd_res_t);

  logic                  f_ready, f_valid, mq_full, mq_empty;
  logic                  b_ready, b_valid, oq_full;
  rshd_mid_t             f_data, mq_data;
  rshd_res_t             b_data, oq_data;
  logic [2:0][CRD_W-1:0] org, dir;

  assign org  = {origin_z_i, origin_y_i, origin_x_i};
  assign dir  = {dir_z_i, dir_y_i, dir_x_i};
  assign full = ~f_ready;

  rshd_front #(.FRAC_BITS(FRAC_BITS)) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (push),
    .in_ready_o  (f_ready),
    .org_i       (org),
    .dir_i       (dir),
    .out_valid_o (f_valid),
    .out_ready_i (~mq_full),
    .out_data_o  (f_data)
  );

  rshd_fifo #(.WIDTH(MID_W), .DEPTH(4)) u_mid_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (f_valid),
    .data_i  (f_data),
    .full_o  (mq_full),
    .pop_i   (b_ready),
    .data_o  (mq_data),
    .empty_o (mq_empty)
  );

  rshd_back #(.FRAC_BITS(FRAC_BITS)) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (~mq_empty),
    .in_ready_o  (b_ready),
    .in_data_i   (mq_data),
    .out_valid_o (b_valid),
    .out_ready_i (~oq_full),
    .out_data_o  (b_data)
  );

  rshd_fifo #(.WIDTH(RES_W), .DEPTH(2)) u_res_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (b_valid),
    .data_i  (b_data),
    .full_o  (oq_full),
    .pop_i   (pop),
    .data_o  (oq_data),
    .empty_o (empty)
  );

  assign hit_o          = oq_data.hit;
  assign hit_distance_o = oq_data.hit_dist;
  assign hit_x_o        = oq_data.pt[0];
  assign hit_y_o        = oq_data.pt[1];
  assign hit_z_o        = oq_data.pt[2];

`ifndef SYNTHESIS
  // A miss carries no distance and no point.
  a_miss_is_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !hit_o) |-> (hit_distance_o == '0 && hit_x_o == '0 &&
                            hit_y_o == '0 && hit_z_o == '0))
    else $error("miss result with nonzero payload");

  // A waiting result is not replaced before it is popped.
  a_result_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !pop) |=> (!empty && $stable(hit_distance_o) && $stable(hit_x_o)))
    else $error("waiting result changed");

  // An item that the back end takes from the middle queue enters its first stage.
  a_mid_pop_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (b_ready && !mq_empty) |=> u_back.v_q[0])
    else $error("back end lost an item from the middle queue");
`endif

endmodule
